// ===== hdl/mdfa_pkg.sv =====
`timescale 1ns / 1ps

package mdfa_pkg;

	localparam int DEF_NUM_PATTERNS = 4;
	localparam int DEF_NUM_STATES   = 64;
	localparam int ROW_W            = 6;
	localparam int MAX_ROWS         = 1 << ROW_W;
	localparam int SYM_W            = 8;
	localparam int SYMBOLS          = 1 << SYM_W;

	typedef enum logic [1:0] {
		OP_LOAD_TRAN = 2'd0,
		OP_LOAD_ACC  = 2'd1,
		OP_BYTE      = 2'd2,
		OP_FINISH    = 2'd3
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [1:0]       pattern_sel;
		logic [ROW_W-1:0] from_state;
		logic [SYM_W-1:0] symbol;
		logic [ROW_W-1:0] next_state;
		logic             accept_bit;
	} in_item_t;

	typedef struct packed {
		logic       matched;
		logic [1:0] pattern_index;
	} out_item_t;

	typedef struct packed {
		logic             load_tran;
		logic             load_acc;
		logic             step;
		logic             finish;
		logic             clr;
		logic [ROW_W-1:0] clr_addr;
	} lane_ctl_t;

	function automatic int eff_rows(input int n);
		return (n < MAX_ROWS) ? n : MAX_ROWS;
	endfunction

endpackage

// ===== hdl/mdfa_lane.sv =====
`timescale 1ns / 1ps

module mdfa_lane import mdfa_pkg::*; #(
	parameter int LANE       = 0,
	parameter int NUM_STATES = DEF_NUM_STATES
) (
	input  logic      clk,
	input  logic      arst_n,
	input  lane_ctl_t ctl,
	input  in_item_t  item,
	output logic      hit_s1
);

	localparam int EFF    = eff_rows(NUM_STATES);
	localparam int SW     = (EFF > 1) ? $clog2(EFF) : 1;
	localparam int TDEPTH = EFF * SYMBOLS;
	localparam int AW     = SW + SYM_W;

	logic [SW-1:0] tran_mem [TDEPTH];
	logic          acc_mem  [EFF];

	logic [SW-1:0] cur_q;
	logic          pend_q;
	logic [SW-1:0] tran_rd_s1;
	logic          dead_s1;
	logic          acc_rd_s1;
	logic          live_s1;

	logic          sel;
	logic          row_ok;
	logic          tgt_ok;
	logic          wr_tran;
	logic          wr_acc;
	logic [SW-1:0] tgt;
	logic [SW-1:0] row;
	logic [SW-1:0] cur_eff;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;

	assign sel     = (int'(item.pattern_sel) == LANE);
	assign row_ok  = (int'(item.from_state) < EFF);
	assign tgt_ok  = (int'(item.next_state) < EFF);
	assign wr_tran = ctl.load_tran && sel && row_ok;
	assign wr_acc  = ctl.load_acc && sel && row_ok;
	assign tgt     = tgt_ok ? item.next_state[SW-1:0] : '0;
	assign row     = item.from_state[SW-1:0];

	// state just read from the table takes over from the register
	assign cur_eff = pend_q ? (dead_s1 ? '0 : tran_rd_s1) : cur_q;
	assign rd_addr = {cur_eff, item.symbol};
	assign wr_addr = {row, item.symbol};

	always_ff @(posedge clk) begin
		if (wr_tran) begin
			tran_mem[wr_addr] <= tgt;
		end
		if (ctl.step) begin
			tran_rd_s1 <= tran_mem[rd_addr];
			dead_s1    <= (cur_eff == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			acc_mem[ctl.clr_addr[SW-1:0]] <= 1'b0;
		end else if (wr_acc) begin
			acc_mem[row] <= item.accept_bit;
		end
		if (ctl.finish) begin
			acc_rd_s1 <= acc_mem[cur_eff];
			live_s1   <= (cur_eff != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= SW'(1);
			pend_q <= 1'b0;
		end else if (ctl.step) begin
			pend_q <= 1'b1;
		end else begin
			pend_q <= 1'b0;
			cur_q  <= ctl.finish ? SW'(1) : cur_eff;
		end
	end

	assign hit_s1 = acc_rd_s1 && live_s1;

endmodule

// ===== hdl/multi_pattern_dfa_matcher_core.sv =====
`timescale 1ns / 1ps
// channel   signals                   carries
// req       req_valid/req_stall/req   load, text byte or finish item
// rsp       rsp_valid/rsp_stall/rsp   match result of a finish item
//
// one item per cycle while req_stall is low; byte items run back to back through the per-pattern
// transition memory, whose registered read data is the next current state
// a finish result is read from the accept memory into a register, then registered onto rsp once rsp is free
// after reset all min(NUM_STATES, 64) rows of the accept memories are cleared, with req_stall high
// req_stall rises when a result waits behind a stalled rsp item

module multi_pattern_dfa_matcher_core import mdfa_pkg::*; #(
	parameter int NUM_PATTERNS = DEF_NUM_PATTERNS,
	parameter int NUM_STATES   = DEF_NUM_STATES
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  in_item_t  req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output out_item_t rsp
);

	localparam int EFF = eff_rows(NUM_STATES);
	localparam int SW  = (EFF > 1) ? $clog2(EFF) : 1;

	logic                    req_acc;
	logic                    out_free;
	logic                    res_v_s1;
	logic                    clr_busy_q;
	logic [SW-1:0]           clr_cnt_q;
	lane_ctl_t               ctl;
	logic [NUM_PATTERNS-1:0] hits;
	logic                    found;
	logic [1:0]              idx;

	assign out_free  = !rsp_valid || !rsp_stall;
	assign req_stall = clr_busy_q || (res_v_s1 && !out_free);
	assign req_acc   = req_valid && !req_stall;

	assign ctl.load_tran = req_acc && (req.op == OP_LOAD_TRAN);
	assign ctl.load_acc  = req_acc && (req.op == OP_LOAD_ACC);
	assign ctl.step      = req_acc && (req.op == OP_BYTE);
	assign ctl.finish    = req_acc && (req.op == OP_FINISH);
	assign ctl.clr       = clr_busy_q;
	assign ctl.clr_addr  = ROW_W'(clr_cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + SW'(1);
			if (clr_cnt_q == SW'(EFF - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	for (genvar g = 0; g < NUM_PATTERNS; g++) begin : g_lane
		mdfa_lane #(
			.LANE       (g),
			.NUM_STATES (NUM_STATES)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.item   (req),
			.hit_s1 (hits[g])
		);
	end

	// lowest-numbered accepting pattern wins
	always_comb begin
		found = 1'b0;
		idx   = '0;
		for (int p = NUM_PATTERNS - 1; p >= 0; p--) begin
			if (hits[p]) begin
				found = 1'b1;
				idx   = 2'(p);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_s1  <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			if (res_v_s1 && out_free) begin
				rsp_valid <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid <= 1'b0;
			end
			if (ctl.finish) begin
				res_v_s1 <= 1'b1;
			end else if (out_free) begin
				res_v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_v_s1 && out_free) begin
			rsp.matched       <= found;
			rsp.pattern_index <= idx;
		end
	end

endmodule

// ===== hdl/mdfa_checker.sv =====
`timescale 1ns / 1ps

module mdfa_checker import mdfa_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_stall,
	input in_item_t  req,
	input logic      rsp_valid,
	input logic      rsp_stall,
	input out_item_t rsp
);

	logic fin_acc;

	assign fin_acc = req_valid && !req_stall && (req.op == OP_FINISH);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled rsp item changed");

	a_no_match_idx: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.matched |-> rsp.pattern_index == 2'd0)
		else $error("pattern index set without a match");

	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(fin_acc, 2))
		else $error("rsp item without a finish item");

	a_finish_latency: assert property (@(posedge clk) disable iff (!arst_n)
		fin_acc |=> ##1 rsp_valid)
		else $error("finish item gave no rsp item in time");

endmodule

bind multi_pattern_dfa_matcher_core mdfa_checker u_mdfa_checker (.*);

// ===== test/tb_multi_pattern_dfa_matcher_core.sv =====
`timescale 1ns / 1ps

module tb_multi_pattern_dfa_matcher_core;
	import mdfa_pkg::*;

	localparam int CYCLE_LIMIT   = 300000;
	localparam int STREAM_ITEMS  = 440;
	localparam int TEXT_SYMS     = 6;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	in_item_t  req       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	out_item_t rsp;

	multi_pattern_dfa_matcher_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	// matcher state as seen from the accepted items
	logic [ROW_W-1:0] tran_tab [DEF_NUM_PATTERNS][DEF_NUM_STATES][SYMBOLS];
	logic             acc_tab  [DEF_NUM_PATTERNS][DEF_NUM_STATES];
	logic [ROW_W-1:0] cur_row  [DEF_NUM_PATTERNS];

	in_item_t         req_items[$];
	out_item_t        pending_matches[$];
	out_item_t        want_rsp;
	logic [ROW_W-1:0] live_rows[$];
	logic [SYM_W-1:0] text_syms[$];

	int send_idle_pct  = 10;
	int recv_stall_pct = 46;
	int n_queued       = 0;
	int n_accepted     = 0;
	int n_errors       = 0;
	int n_loads        = 0;
	int n_bytes        = 0;
	int n_finish       = 0;
	int n_matched      = 0;
	int hits [DEF_NUM_PATTERNS];
	int cycles         = 0;

	always #1 clk = ~clk;

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic void advance_matcher(input in_item_t it);
		out_item_t res;
		int p;
		case (it.op)
			OP_LOAD_TRAN: begin
				if (it.pattern_sel < DEF_NUM_PATTERNS && it.from_state < DEF_NUM_STATES)
					tran_tab[it.pattern_sel][it.from_state][it.symbol] =
						(it.next_state < DEF_NUM_STATES) ? it.next_state : '0;
				n_loads++;
			end
			OP_LOAD_ACC: begin
				if (it.pattern_sel < DEF_NUM_PATTERNS && it.from_state < DEF_NUM_STATES)
					acc_tab[it.pattern_sel][it.from_state] = it.accept_bit;
				n_loads++;
			end
			OP_BYTE: begin
				for (p = 0; p < DEF_NUM_PATTERNS; p++)
					cur_row[p] = (cur_row[p] != 0 && cur_row[p] < DEF_NUM_STATES) ?
						tran_tab[p][cur_row[p]][it.symbol] : '0;
				n_bytes++;
			end
			OP_FINISH: begin
				res = '0;
				for (p = 0; p < DEF_NUM_PATTERNS; p++) begin
					if (!res.matched && cur_row[p] != 0 && cur_row[p] < DEF_NUM_STATES &&
						acc_tab[p][cur_row[p]]) begin
						res.matched       = 1'b1;
						res.pattern_index = p[1:0];
						hits[p]++;
					end
					cur_row[p] = ROW_W'(1);
				end
				if (res.matched)
					n_matched++;
				n_finish++;
				pending_matches = {pending_matches, res};
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void queue_item(input op_t op, input logic [1:0] pat,
		input logic [ROW_W-1:0] from_row, input logic [SYM_W-1:0] sym,
		input logic [ROW_W-1:0] nxt, input logic acc);
		in_item_t it;
		it.op          = op;
		it.pattern_sel = pat;
		it.from_state  = from_row;
		it.symbol      = sym;
		it.next_state  = nxt;
		it.accept_bit  = acc;
		req_items = {req_items, it};
		n_queued++;
	endfunction

	// targets stay inside the live rows or the dead row 0, so no unloaded entry is ever used
	function automatic logic [ROW_W-1:0] pick_next();
		if ($urandom_range(99) < 15)
			return '0;
		return live_rows[$urandom_range(live_rows.size() - 1)];
	endfunction

	task automatic run_phase(input int send_pct, input int recv_pct, input bit extremes);
		bit               row_taken [DEF_NUM_STATES];
		bit               sym_taken [SYMBOLS];
		logic [ROW_W-1:0] r;
		logic [SYM_W-1:0] s;
		int               p;
		int               row_goal;
		int               stop_at;
		int               len;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		live_rows      = {};
		text_syms      = {};
		row_goal       = 3 + $urandom_range(2);
		live_rows      = {live_rows, ROW_W'(1)};
		row_taken[1] = 1'b1;
		if (extremes) begin
			live_rows = {live_rows, ROW_W'(DEF_NUM_STATES - 1)};
			row_taken[DEF_NUM_STATES - 1] = 1'b1;
			text_syms = {text_syms, 8'h00};
			text_syms = {text_syms, 8'hFF};
			sym_taken[8'h00] = 1'b1;
			sym_taken[8'hFF] = 1'b1;
		end
		while (live_rows.size() < row_goal) begin
			r = ROW_W'($urandom_range(DEF_NUM_STATES - 1, 2));
			if (!row_taken[r]) begin
				row_taken[r] = 1'b1;
				live_rows = {live_rows, r};
			end
		end
		while (text_syms.size() < TEXT_SYMS) begin
			s = SYM_W'($urandom);
			if (!sym_taken[s]) begin
				sym_taken[s] = 1'b1;
				text_syms = {text_syms, s};
			end
		end

		// full tables over the live rows and the text alphabet
		for (p = 0; p < DEF_NUM_PATTERNS; p++) begin
			foreach (live_rows[i]) begin
				foreach (text_syms[j])
					queue_item(OP_LOAD_TRAN, 2'(p), live_rows[i], text_syms[j], pick_next(),
						1'($urandom));
				queue_item(OP_LOAD_ACC, 2'(p), live_rows[i], SYM_W'($urandom),
					ROW_W'($urandom), $urandom_range(99) < 35);
			end
		end

		// strings of text, each closed by a finish, with stray loads mixed in
		stop_at = n_queued + STREAM_ITEMS;
		while (n_queued < stop_at) begin
			len = ($urandom_range(7) == 0) ? $urandom_range(20) : $urandom_range(6);
			repeat (len) begin
				if ($urandom_range(99) < 6) begin
					if ($urandom_range(1))
						queue_item(OP_LOAD_TRAN, 2'($urandom), ROW_W'($urandom),
							SYM_W'($urandom), pick_next(), 1'($urandom));
					else
						queue_item(OP_LOAD_ACC, 2'($urandom), ROW_W'($urandom),
							SYM_W'($urandom), ROW_W'($urandom), 1'($urandom));
				end
				queue_item(OP_BYTE, 2'($urandom), ROW_W'($urandom),
					text_syms[$urandom_range(text_syms.size() - 1)], ROW_W'($urandom),
					1'($urandom));
			end
			queue_item(OP_FINISH, 2'($urandom), ROW_W'($urandom), SYM_W'($urandom),
				ROW_W'($urandom), 1'($urandom));
		end

		// sender holds off until every result is back
		while (n_accepted < n_queued || pending_matches.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		for (int p = 0; p < DEF_NUM_PATTERNS; p++) begin
			cur_row[p] = ROW_W'(1);
			hits[p]    = 0;
			for (int q = 0; q < DEF_NUM_STATES; q++)
				acc_tab[p][q] = 1'b0;
		end

		// accept flags are clear straight after reset
		queue_item(OP_FINISH, 2'd0, 6'd0, 8'h00, 6'd0, 1'b0);
		queue_item(OP_LOAD_TRAN, 2'd0, 6'd1, 8'h00, 6'd0, 1'b0);
		// dead row loaded with a live target and flagged accepting, still absorbing
		queue_item(OP_LOAD_TRAN, 2'd0, 6'd0, 8'h00, 6'd1, 1'b0);
		queue_item(OP_LOAD_ACC, 2'd0, 6'd0, 8'h00, 6'd0, 1'b1);
		queue_item(OP_LOAD_ACC, 2'd0, 6'd1, 8'h00, 6'd0, 1'b1);
		queue_item(OP_LOAD_TRAN, 2'd0, 6'd1, 8'hFF, 6'd1, 1'b0);
		queue_item(OP_LOAD_TRAN, 2'd1, 6'd1, 8'h00, 6'd0, 1'b0);
		queue_item(OP_LOAD_TRAN, 2'd1, 6'd1, 8'hFF, 6'd0, 1'b0);
		queue_item(OP_LOAD_TRAN, 2'd2, 6'd1, 8'h00, 6'd0, 1'b0);
		queue_item(OP_LOAD_TRAN, 2'd2, 6'd1, 8'hFF, 6'd0, 1'b0);
		queue_item(OP_LOAD_TRAN, 2'd3, 6'd1, 8'h00, 6'd63, 1'b0);
		queue_item(OP_LOAD_TRAN, 2'd3, 6'd1, 8'hFF, 6'd63, 1'b0);
		queue_item(OP_LOAD_TRAN, 2'd3, 6'd63, 8'hFF, 6'd63, 1'b1);
		queue_item(OP_LOAD_TRAN, 2'd3, 6'd63, 8'h00, 6'd0, 1'b1);
		queue_item(OP_LOAD_ACC, 2'd3, 6'd63, 8'hFF, 6'd63, 1'b1);
		queue_item(OP_FINISH, 2'd3, 6'd63, 8'hFF, 6'd63, 1'b1);
		queue_item(OP_BYTE, 2'd0, 6'd0, 8'hFF, 6'd0, 1'b0);
		queue_item(OP_FINISH, 2'd0, 6'd0, 8'h00, 6'd0, 1'b0);
		// lower patterns dead, pattern 3 reports
		queue_item(OP_BYTE, 2'd3, 6'd63, 8'h00, 6'd63, 1'b1);
		queue_item(OP_FINISH, 2'd0, 6'd0, 8'h00, 6'd0, 1'b0);
		queue_item(OP_BYTE, 2'd0, 6'd0, 8'h00, 6'd0, 1'b0);
		queue_item(OP_BYTE, 2'd0, 6'd0, 8'h00, 6'd0, 1'b0);
		queue_item(OP_FINISH, 2'd0, 6'd0, 8'h00, 6'd0, 1'b0);
		queue_item(OP_LOAD_ACC, 2'd0, 6'd1, 8'h00, 6'd0, 1'b0);
		queue_item(OP_BYTE, 2'd0, 6'd0, 8'hFF, 6'd0, 1'b0);
		queue_item(OP_FINISH, 2'd0, 6'd0, 8'h00, 6'd0, 1'b0);

		run_phase(10, 46, 1'b1);
		run_phase(46, 10, 1'b0);
		run_phase(0, 0, 1'b0);

		repeat (16) @(posedge clk);
		$display("covered %0d items: %0d loads, %0d text bytes, %0d strings, %0d matched",
			n_accepted, n_loads, n_bytes, n_finish, n_matched);
		$display("matches by pattern: %0d %0d %0d %0d", hits[0], hits[1], hits[2], hits[3]);
		if (n_errors == 0) begin
			$display("** multi_pattern_dfa_matcher_core: PASSED **");
		end else begin
			$display("** multi_pattern_dfa_matcher_core: FAILED **");
		end
		$finish;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && !req_stall) begin
				advance_matcher(req);
				n_accepted++;
			end
			if (!req_valid || !req_stall) begin
				if (req_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req_valid <= 1'b1;
					req       <= req_items.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_matches.size() == 0) begin
					$error("result with no finish item waiting: matched %0b pattern_index %0d",
						rsp.matched, rsp.pattern_index);
					n_errors++;
				end else begin
					want_rsp = pending_matches.pop_front();
					if (rsp.matched !== want_rsp.matched) begin
						$error("matched: expected %0b, got %0b", want_rsp.matched, rsp.matched);
						n_errors++;
					end
					if (rsp.pattern_index !== want_rsp.pattern_index) begin
						$error("pattern_index: expected %0d, got %0d",
							want_rsp.pattern_index, rsp.pattern_index);
						n_errors++;
					end
				end
			end
			rsp_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$error("timeout after %0d cycles, %0d of %0d items accepted, %0d results missing",
				cycles, n_accepted, n_queued, pending_matches.size());
			$display("** multi_pattern_dfa_matcher_core: FAILED **");
			$finish;
		end
	end

endmodule
